// ===== design/stri_pkg.sv =====
// Shared types, constants and the micro-program of the segment/triangle test.
// Used by every module of the block; depends on nothing.
`default_nettype none
package stri_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int S_FRAC_BITS = 31;
   localparam int FIELD_W     = 32;
   localparam int PARAM_S_W   = 32;

   // Widest exact intermediate is A+B with a sign bit to spare.
   localparam int LIMB        = 32;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int W_NEED      = 7 * DIFF_W + 12;
   localparam int NLIMB       = (W_NEED + LIMB - 1) / LIMB;
   localparam int W           = NLIMB * LIMB;
   localparam int LIMB_IDX_W  = $clog2(NLIMB);
   localparam int SHIFT_W     = LIMB_IDX_W + 1;

   localparam int Q_W         = S_FRAC_BITS + 1;
   localparam int QX_W        = (Q_W > PARAM_S_W + 1) ? Q_W : PARAM_S_W + 1;
   localparam int DIV_CNT_W   = $clog2(S_FRAC_BITS + 1);

   localparam int RF_DEPTH     = 64;
   localparam int RF_ADDR_W    = $clog2(RF_DEPTH);
   localparam int NUM_AXES     = 3;
   localparam int NUM_VERTS    = 3;
   localparam int NUM_VTX_REGS = NUM_VERTS * NUM_AXES;
   localparam int VTX_IDX_W    = $clog2(NUM_VTX_REGS);
   localparam int NUM_IN_COORD = 6;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   typedef logic [W-1:0]         wide_type;
   typedef logic [RF_ADDR_W-1:0] addr_type;

   // register file map
   localparam int R_V0  = 0;
   localparam int R_V1  = 3;
   localparam int R_V2  = 6;
   localparam int R_P1  = 9;
   localparam int R_P2  = 12;
   localparam int R_E1  = 15;
   localparam int R_E2  = 18;
   localparam int R_U   = 21;
   localparam int R_X0  = 24;
   localparam int R_N   = 27;
   localparam int R_UN  = 30;
   localparam int R_XN  = 31;
   localparam int R_NUM = 32;
   localparam int R_DEN = 33;
   localparam int R_TMP = 34;
   localparam int R_X   = 35;
   localparam int R_VV  = 38;
   localparam int R_VW  = 39;
   localparam int R_WW  = 40;
   localparam int R_DD  = 41;
   localparam int R_DXW = 42;
   localparam int R_DXV = 43;
   localparam int R_A   = 44;
   localparam int R_B   = 45;
   localparam int R_E   = 46;
   localparam int R_S   = 47;

   typedef enum logic [3:0] {
      UOP_LDC,
      UOP_ADD,
      UOP_SUB,
      UOP_ABS,
      UOP_NABS,
      UOP_MUL,
      UOP_FZERO,
      UOP_FNEG,
      UOP_FNPOS,
      UOP_DIV,
      UOP_HALT
   } uop_opc_type;

   typedef struct packed {
      uop_opc_type opc;
      addr_type    dst;
      addr_type    sa;
      addr_type    sb;
      logic        clr;
      logic        neg;
      logic        wr;
   } uop_type;

   typedef struct packed {
      logic start;
      logic clr;
      logic neg;
   } mul_ctl_type;

   localparam int UCODE_LEN = 76;
   localparam int PC_W      = $clog2(UCODE_LEN);

   function automatic uop_type mk(uop_opc_type opc, int dst, int sa, int sb,
                                  logic clr, logic neg, logic wr);
      uop_type u;
      u.opc = opc;
      u.dst = addr_type'(dst);
      u.sa  = addr_type'(sa);
      u.sb  = addr_type'(sb);
      u.clr = clr;
      u.neg = neg;
      u.wr  = wr;
      return u;
   endfunction

   function automatic wide_type sext(logic [COORD_WIDTH-1:0] c);
      return {{(W-COORD_WIDTH){c[COORD_WIDTH-1]}}, c};
   endfunction

   function automatic logic [COORD_WIDTH-1:0] field_coord(logic [FIELD_W-1:0] f);
      return COORD_WIDTH'({{COORD_WIDTH{1'b0}}, f});
   endfunction

   // Micro-program: copy the segment in, form edges, normal, the crossing
   // test, the barycentric test and finally the quotient for s.
   function automatic uop_type ucode(logic [PC_W-1:0] pc);
      uop_type u;
      case (pc)
         0:  u = mk(UOP_LDC,  R_P1,   0, 0, 0, 0, 0);
         1:  u = mk(UOP_LDC,  R_P1+1, 0, 0, 0, 0, 0);
         2:  u = mk(UOP_LDC,  R_P1+2, 0, 0, 0, 0, 0);
         3:  u = mk(UOP_LDC,  R_P2,   0, 0, 0, 0, 0);
         4:  u = mk(UOP_LDC,  R_P2+1, 0, 0, 0, 0, 0);
         5:  u = mk(UOP_LDC,  R_P2+2, 0, 0, 0, 0, 0);
         6:  u = mk(UOP_SUB,  R_E1,   R_V1,   R_V0,   0, 0, 0);
         7:  u = mk(UOP_SUB,  R_E1+1, R_V1+1, R_V0+1, 0, 0, 0);
         8:  u = mk(UOP_SUB,  R_E1+2, R_V1+2, R_V0+2, 0, 0, 0);
         9:  u = mk(UOP_SUB,  R_E2,   R_V2,   R_V0,   0, 0, 0);
         10: u = mk(UOP_SUB,  R_E2+1, R_V2+1, R_V0+1, 0, 0, 0);
         11: u = mk(UOP_SUB,  R_E2+2, R_V2+2, R_V0+2, 0, 0, 0);
         12: u = mk(UOP_SUB,  R_U,    R_P2,   R_P1,   0, 0, 0);
         13: u = mk(UOP_SUB,  R_U+1,  R_P2+1, R_P1+1, 0, 0, 0);
         14: u = mk(UOP_SUB,  R_U+2,  R_P2+2, R_P1+2, 0, 0, 0);
         15: u = mk(UOP_SUB,  R_X0,   R_P1,   R_V0,   0, 0, 0);
         16: u = mk(UOP_SUB,  R_X0+1, R_P1+1, R_V0+1, 0, 0, 0);
         17: u = mk(UOP_SUB,  R_X0+2, R_P1+2, R_V0+2, 0, 0, 0);
         // n = e1 x e2
         18: u = mk(UOP_MUL,  R_N,    R_E1+1, R_E2+2, 1, 0, 0);
         19: u = mk(UOP_MUL,  R_N,    R_E1+2, R_E2+1, 0, 1, 1);
         20: u = mk(UOP_MUL,  R_N+1,  R_E1+2, R_E2,   1, 0, 0);
         21: u = mk(UOP_MUL,  R_N+1,  R_E1,   R_E2+2, 0, 1, 1);
         22: u = mk(UOP_MUL,  R_N+2,  R_E1,   R_E2+1, 1, 0, 0);
         23: u = mk(UOP_MUL,  R_N+2,  R_E1+1, R_E2,   0, 1, 1);
         24: u = mk(UOP_MUL,  R_UN,   R_U,    R_N,    1, 0, 0);
         25: u = mk(UOP_MUL,  R_UN,   R_U+1,  R_N+1,  0, 0, 0);
         26: u = mk(UOP_MUL,  R_UN,   R_U+2,  R_N+2,  0, 0, 1);
         27: u = mk(UOP_FZERO, 0,     R_UN,   0,      0, 0, 0);
         28: u = mk(UOP_MUL,  R_XN,   R_X0,   R_N,    1, 0, 0);
         29: u = mk(UOP_MUL,  R_XN,   R_X0+1, R_N+1,  0, 0, 0);
         30: u = mk(UOP_MUL,  R_XN,   R_X0+2, R_N+2,  0, 0, 1);
         31: u = mk(UOP_NABS, R_NUM,  R_XN,   R_UN,   0, 0, 0);
         32: u = mk(UOP_ABS,  R_DEN,  R_UN,   R_UN,   0, 0, 0);
         33: u = mk(UOP_FNPOS, 0,     R_NUM,  0,      0, 0, 0);
         34: u = mk(UOP_SUB,  R_TMP,  R_DEN,  R_NUM,  0, 0, 0);
         35: u = mk(UOP_FNEG, 0,      R_TMP,  0,      0, 0, 0);
         // crossing point relative to v0, scaled by dot(u, n)
         36: u = mk(UOP_MUL,  R_X,    R_X0,   R_UN,   1, 0, 0);
         37: u = mk(UOP_MUL,  R_X,    R_XN,   R_U,    0, 1, 1);
         38: u = mk(UOP_MUL,  R_X+1,  R_X0+1, R_UN,   1, 0, 0);
         39: u = mk(UOP_MUL,  R_X+1,  R_XN,   R_U+1,  0, 1, 1);
         40: u = mk(UOP_MUL,  R_X+2,  R_X0+2, R_UN,   1, 0, 0);
         41: u = mk(UOP_MUL,  R_X+2,  R_XN,   R_U+2,  0, 1, 1);
         42: u = mk(UOP_MUL,  R_VV,   R_E1,   R_E1,   1, 0, 0);
         43: u = mk(UOP_MUL,  R_VV,   R_E1+1, R_E1+1, 0, 0, 0);
         44: u = mk(UOP_MUL,  R_VV,   R_E1+2, R_E1+2, 0, 0, 1);
         45: u = mk(UOP_MUL,  R_VW,   R_E1,   R_E2,   1, 0, 0);
         46: u = mk(UOP_MUL,  R_VW,   R_E1+1, R_E2+1, 0, 0, 0);
         47: u = mk(UOP_MUL,  R_VW,   R_E1+2, R_E2+2, 0, 0, 1);
         48: u = mk(UOP_MUL,  R_WW,   R_E2,   R_E2,   1, 0, 0);
         49: u = mk(UOP_MUL,  R_WW,   R_E2+1, R_E2+1, 0, 0, 0);
         50: u = mk(UOP_MUL,  R_WW,   R_E2+2, R_E2+2, 0, 0, 1);
         51: u = mk(UOP_MUL,  R_DD,   R_VW,   R_VW,   1, 0, 0);
         52: u = mk(UOP_MUL,  R_DD,   R_VV,   R_WW,   0, 1, 1);
         53: u = mk(UOP_FZERO, 0,     R_DD,   0,      0, 0, 0);
         54: u = mk(UOP_MUL,  R_DXW,  R_X,    R_E2,   1, 0, 0);
         55: u = mk(UOP_MUL,  R_DXW,  R_X+1,  R_E2+1, 0, 0, 0);
         56: u = mk(UOP_MUL,  R_DXW,  R_X+2,  R_E2+2, 0, 0, 1);
         57: u = mk(UOP_MUL,  R_DXV,  R_X,    R_E1,   1, 0, 0);
         58: u = mk(UOP_MUL,  R_DXV,  R_X+1,  R_E1+1, 0, 0, 0);
         59: u = mk(UOP_MUL,  R_DXV,  R_X+2,  R_E1+2, 0, 0, 1);
         60: u = mk(UOP_MUL,  R_A,    R_VW,   R_DXW,  1, 0, 0);
         61: u = mk(UOP_MUL,  R_A,    R_WW,   R_DXV,  0, 1, 1);
         62: u = mk(UOP_MUL,  R_B,    R_VW,   R_DXV,  1, 0, 0);
         63: u = mk(UOP_MUL,  R_B,    R_VV,   R_DXW,  0, 1, 1);
         64: u = mk(UOP_MUL,  R_E,    R_UN,   R_DD,   1, 0, 1);
         // fold sign of E into A and B before E itself
         65: u = mk(UOP_ABS,  R_A,    R_A,    R_E,    0, 0, 0);
         66: u = mk(UOP_ABS,  R_B,    R_B,    R_E,    0, 0, 0);
         67: u = mk(UOP_ABS,  R_E,    R_E,    R_E,    0, 0, 0);
         68: u = mk(UOP_FNEG, 0,      R_A,    0,      0, 0, 0);
         69: u = mk(UOP_SUB,  R_TMP,  R_E,    R_A,    0, 0, 0);
         70: u = mk(UOP_FNEG, 0,      R_TMP,  0,      0, 0, 0);
         71: u = mk(UOP_FNEG, 0,      R_B,    0,      0, 0, 0);
         72: u = mk(UOP_ADD,  R_S,    R_A,    R_B,    0, 0, 0);
         73: u = mk(UOP_SUB,  R_TMP,  R_E,    R_S,    0, 0, 0);
         74: u = mk(UOP_FNEG, 0,      R_TMP,  0,      0, 0, 0);
         75: u = mk(UOP_DIV,  0,      R_NUM,  R_DEN,  0, 0, 0);
         default: u = mk(UOP_HALT, 0, 0, 0, 0, 0, 0);
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

// ===== design/stri_regfile.sv =====
// Wide register file: one write port, two registered read ports.
// Vertex entries carry valid bits so they read as zero after reset. Uses stri_pkg.
`default_nettype none
module stri_regfile (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  stri_pkg::addr_type wr_addr,
   input  stri_pkg::wide_type wr_data,
   input  stri_pkg::addr_type rd_addr_a,
   input  stri_pkg::addr_type rd_addr_b,
   output stri_pkg::wide_type rd_data_a,
   output stri_pkg::wide_type rd_data_b
);
   import stri_pkg::*;

   wide_type mem [RF_DEPTH];
   wide_type q_a_ff, q_b_ff;
   logic     live_a_ff, live_b_ff;
   logic     live_a_in, live_b_in;
   logic [NUM_VTX_REGS-1:0] vld_ff;

   always_comb begin
      live_a_in = 1'b1;
      live_b_in = 1'b1;
      if (rd_addr_a < addr_type'(NUM_VTX_REGS)) begin
         live_a_in = vld_ff[rd_addr_a[VTX_IDX_W-1:0]];
      end
      if (rd_addr_b < addr_type'(NUM_VTX_REGS)) begin
         live_b_in = vld_ff[rd_addr_b[VTX_IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_a_ff    <= mem[rd_addr_a];
      q_b_ff    <= mem[rd_addr_b];
      live_a_ff <= live_a_in;
      live_b_ff <= live_b_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en && (wr_addr < addr_type'(NUM_VTX_REGS))) begin
         vld_ff[wr_addr[VTX_IDX_W-1:0]] <= 1'b1;
      end
   end

   assign rd_data_a = live_a_ff ? q_a_ff : '0;
   assign rd_data_b = live_b_ff ? q_b_ff : '0;

endmodule
`default_nettype wire

// ===== design/stri_mul.sv =====
// Multi-limb signed multiply-accumulate on one 32x32 multiplier.
// Two's-complement operands taken as sign and magnitude, one limb product per cycle. Uses stri_pkg.
`default_nettype none
module stri_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  stri_pkg::mul_ctl_type ctl,
   input  stri_pkg::wide_type    op_a,
   input  stri_pkg::wide_type    op_b,
   output logic                  done,
   output stri_pkg::wide_type    acc
);
   import stri_pkg::*;

   typedef enum logic [3:0] {
      M_IDLE  = 4'b0001,
      M_PREP  = 4'b0010,
      M_RUN   = 4'b0100,
      M_DRAIN = 4'b1000
   } mstate_type;

   mstate_type mstate_ff, mstate_in;
   wide_type   mag_a_ff, mag_b_ff, acc_ff, a_abs, b_abs, term;
   logic       sub_ff, pvalid_ff, done_ff;
   logic [LIMB_IDX_W-1:0] hi_a_ff, hi_b_ff, i_ff, j_ff, hi_a, hi_b;
   logic [2*LIMB-1:0]     prod_ff;
   logic [SHIFT_W-1:0]    pshift_ff;
   logic                  last;

   assign a_abs = op_a[W-1] ? (~op_a + W'(1)) : op_a;
   assign b_abs = op_b[W-1] ? (~op_b + W'(1)) : op_b;

   // highest nonzero limb of each magnitude
   always_comb begin
      hi_a = '0;
      hi_b = '0;
      for (int l = 0; l < NLIMB; l++) begin
         if (mag_a_ff[l*LIMB +: LIMB] != '0) hi_a = LIMB_IDX_W'(l);
         if (mag_b_ff[l*LIMB +: LIMB] != '0) hi_b = LIMB_IDX_W'(l);
      end
   end

   assign last = (i_ff == hi_a_ff) && (j_ff == hi_b_ff);
   assign term = W'(prod_ff) << (int'(pshift_ff) * LIMB);

   always_comb begin
      mstate_in = mstate_ff;
      case (mstate_ff)
         M_IDLE:  if (ctl.start) mstate_in = M_PREP;
         M_PREP:  mstate_in = M_RUN;
         M_RUN:   if (last) mstate_in = M_DRAIN;
         M_DRAIN: mstate_in = M_IDLE;
         default: mstate_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mstate_ff <= M_IDLE;
         pvalid_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         mstate_ff <= mstate_in;
         pvalid_ff <= (mstate_ff == M_RUN);
         done_ff   <= (mstate_ff == M_DRAIN);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         mag_a_ff <= a_abs;
         mag_b_ff <= b_abs;
         sub_ff   <= op_a[W-1] ^ op_b[W-1] ^ ctl.neg;
         if (ctl.clr) acc_ff <= '0;
      end else if (pvalid_ff) begin
         acc_ff <= acc_ff + (term ^ {W{sub_ff}}) + W'(sub_ff);
      end
      if (mstate_ff == M_PREP) begin
         hi_a_ff <= hi_a;
         hi_b_ff <= hi_b;
         i_ff    <= '0;
         j_ff    <= '0;
      end
      if (mstate_ff == M_RUN) begin
         prod_ff   <= mag_a_ff[i_ff*LIMB +: LIMB] * mag_b_ff[j_ff*LIMB +: LIMB];
         pshift_ff <= SHIFT_W'(i_ff) + SHIFT_W'(j_ff);
         if (j_ff == hi_b_ff) begin
            j_ff <= '0;
            i_ff <= i_ff + 1'b1;
         end else begin
            j_ff <= j_ff + 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule
`default_nettype wire

// ===== design/stri_div.sv =====
// Restoring divider for the crossing parameter: one quotient bit per cycle.
// Expects 0 < num <= den. Uses stri_pkg.
`default_nettype none
module stri_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  stri_pkg::wide_type     num,
   input  stri_pkg::wide_type     den,
   output logic                   done,
   output logic [stri_pkg::Q_W-1:0] quot
);
   import stri_pkg::*;

   wide_type r_ff, den_ff, rr;
   logic [Q_W-1:0]       q_ff, qq;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 run_ff, done_ff;
   logic [W:0]           diff;
   logic                 ge;

   // first step compares without doubling
   assign rr   = (cnt_ff == '0) ? r_ff : {r_ff[W-2:0], 1'b0};
   assign qq   = (cnt_ff == '0) ? q_ff : {q_ff[Q_W-2:0], 1'b0};
   assign diff = {1'b0, rr} - {1'b0, den_ff};
   assign ge   = ~diff[W];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= run_ff && (cnt_ff == DIV_CNT_W'(S_FRAC_BITS));
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && (cnt_ff == DIV_CNT_W'(S_FRAC_BITS))) begin
            run_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff   <= num;
         den_ff <= den;
         q_ff   <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         r_ff   <= ge ? diff[W-1:0] : rr;
         q_ff   <= {qq[Q_W-1:1], ge};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
`default_nettype wire

// ===== design/segment_triangle_intersect.sv =====
// Segment/triangle intersection test: sequencer, shared ALU and top level.
// Instantiates stri_regfile, stri_mul and stri_div; uses stri_pkg.
//
// Usage: a request is taken when start is high and busy is low.
// req_op low loads one triangle vertex (req_vertex_index 0..2, req_ax/ay/az);
// index 3 is ignored. A load gives no response; busy stays high while its three coordinates are written.
// req_op high tests the segment req_a* -> req_b* against the stored triangle
// and gives exactly one response: rsp_valid high for one cycle with rsp_hit
// and rsp_param_s (Q1.31, zero on a miss). The receiver cannot stall it.
// A test runs a 76-step micro-program; each ALU or flag step passes through fetch and execute,
// each multiply step runs (limbs of a)*(limbs of b) limb products on the single
// 32x32 limb multiplier, and the final quotient is formed bit by bit on the divider.
// The multiplier sets the run time of a full hit; misses end
// at the first failing check. busy stays high until the response is out.
// Reset (synchronous) returns to idle and clears all stored vertices to zero.
`default_nettype none
module segment_triangle_intersect (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [1:0]  req_vertex_index,
   input  logic signed [31:0] req_ax,
   input  logic signed [31:0] req_ay,
   input  logic signed [31:0] req_az,
   input  logic signed [31:0] req_bx,
   input  logic signed [31:0] req_by,
   input  logic signed [31:0] req_bz,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [31:0] rsp_param_s
);
   import stri_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LOAD  = 6'b000010,
      S_FETCH = 6'b000100,
      S_EXEC  = 6'b001000,
      S_MUL   = 6'b010000,
      S_DIV   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic [1:0]      k_ff, k_in, idx_ff;
   logic [COORD_WIDTH-1:0] sh_ff [NUM_IN_COORD];
   logic            shift_en, accept;
   uop_type         uop;

   logic        wr_en;
   addr_type    wr_addr;
   wide_type    wr_data, rd_a, rd_b, alu_y, op1, op2, mul_acc;
   mul_ctl_type mul_ctl;
   logic        mul_done, div_start, div_done;
   logic [Q_W-1:0]  div_q;
   logic [QX_W-1:0] q_ext;
   logic [PARAM_S_W-1:0] q_sat;
   logic        is_abs, neg_sel, inv;
   logic        fin_miss, fin_hit;
   logic        rsp_valid_ff, rsp_hit_ff;
   logic [PARAM_S_W-1:0] rsp_param_ff;

   assign accept = start && (state_ff == S_IDLE);
   assign uop    = ucode(pc_ff);

   // shared adder: add, subtract, conditional negate
   always_comb begin
      is_abs  = (uop.opc == UOP_ABS) || (uop.opc == UOP_NABS);
      neg_sel = (uop.opc == UOP_ABS) ? rd_b[W-1] : ~rd_b[W-1];
      op1     = is_abs ? '0 : rd_a;
      op2     = is_abs ? rd_a : rd_b;
      inv     = (uop.opc == UOP_SUB) || (is_abs && neg_sel);
      alu_y   = op1 + (op2 ^ {W{inv}}) + W'(inv);
   end

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      k_in      = k_ff;
      wr_en     = 1'b0;
      wr_addr   = uop.dst;
      wr_data   = alu_y;
      shift_en  = 1'b0;
      mul_ctl   = '0;
      div_start = 1'b0;
      fin_miss  = 1'b0;
      fin_hit   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_op == OP_TEST) begin
                  state_in = S_FETCH;
                  pc_in    = '0;
               end else if (req_vertex_index < 2'(NUM_VERTS)) begin
                  state_in = S_LOAD;
                  k_in     = '0;
               end
            end
         end
         S_LOAD: begin
            wr_en    = 1'b1;
            wr_addr  = addr_type'(int'(idx_ff) * NUM_AXES + int'(k_ff));
            wr_data  = sext(sh_ff[0]);
            shift_en = 1'b1;
            k_in     = k_ff + 1'b1;
            if (k_ff == 2'(NUM_AXES - 1)) state_in = S_IDLE;
         end
         S_FETCH: state_in = S_EXEC;
         S_EXEC: begin
            case (uop.opc)
               UOP_LDC: begin
                  wr_en    = 1'b1;
                  wr_data  = sext(sh_ff[0]);
                  shift_en = 1'b1;
                  pc_in    = pc_ff + 1'b1;
                  state_in = S_FETCH;
               end
               UOP_ADD, UOP_SUB, UOP_ABS, UOP_NABS: begin
                  wr_en    = 1'b1;
                  pc_in    = pc_ff + 1'b1;
                  state_in = S_FETCH;
               end
               UOP_MUL: begin
                  mul_ctl.start = 1'b1;
                  mul_ctl.clr   = uop.clr;
                  mul_ctl.neg   = uop.neg;
                  state_in      = S_MUL;
               end
               UOP_FZERO, UOP_FNEG, UOP_FNPOS: begin
                  if (((uop.opc == UOP_FZERO) && (rd_a == '0)) ||
                      ((uop.opc == UOP_FNEG) && rd_a[W-1]) ||
                      ((uop.opc == UOP_FNPOS) && (rd_a[W-1] || (rd_a == '0)))) begin
                     fin_miss = 1'b1;
                  end else begin
                     pc_in    = pc_ff + 1'b1;
                     state_in = S_FETCH;
                  end
               end
               UOP_DIV: begin
                  div_start = 1'b1;
                  state_in  = S_DIV;
               end
               default: fin_miss = 1'b1;
            endcase
         end
         S_MUL: begin
            if (mul_done) begin
               wr_en    = uop.wr;
               wr_data  = mul_acc;
               pc_in    = pc_ff + 1'b1;
               state_in = S_FETCH;
            end
         end
         S_DIV: if (div_done) fin_hit = 1'b1;
         default: state_in = S_IDLE;
      endcase
      if (fin_miss || fin_hit) state_in = S_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= fin_miss || fin_hit;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff <= pc_in;
      k_ff  <= k_in;
      if (accept) begin
         idx_ff   <= req_vertex_index;
         sh_ff[0] <= field_coord(req_ax);
         sh_ff[1] <= field_coord(req_ay);
         sh_ff[2] <= field_coord(req_az);
         sh_ff[3] <= field_coord(req_bx);
         sh_ff[4] <= field_coord(req_by);
         sh_ff[5] <= field_coord(req_bz);
      end else if (shift_en) begin
         for (int i = 0; i < NUM_IN_COORD - 1; i++) sh_ff[i] <= sh_ff[i+1];
      end
      if (fin_miss || fin_hit) begin
         rsp_hit_ff   <= fin_hit;
         rsp_param_ff <= fin_hit ? q_sat : '0;
      end
   end

   assign q_ext = QX_W'(div_q);
   assign q_sat = (q_ext[QX_W-1:PARAM_S_W] != '0) ? '1 : q_ext[PARAM_S_W-1:0];

   stri_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (uop.sa),
      .rd_addr_b (uop.sb),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   stri_mul u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mul_ctl),
      .op_a  (rd_a),
      .op_b  (rd_b),
      .done  (mul_done),
      .acc   (mul_acc)
   );

   stri_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (rd_a),
      .den   (rd_b),
      .done  (div_done),
      .quot  (div_q)
   );

   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_param_s = rsp_param_ff;

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe longer than one cycle");
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD) |=> !rsp_valid) else $error("vertex load produced a response");
   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL)) else $error("multiplier finished outside wait");
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV)) else $error("divider finished outside wait");
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> (pc_ff < PC_W'(UCODE_LEN))) else $error("program counter ran off");

endmodule
`default_nettype wire

// ===== dv/tb_segment_triangle_intersect.sv =====
// Self-checking testbench for segment_triangle_intersect: vertex loads and
// segment tests against an exact wide-integer predictor. Depends on the RTL only.
`timescale 1ns / 1ps
module tb_segment_triangle_intersect;
   import stri_pkg::*;

   typedef logic signed [511:0] big_type;
   typedef logic signed [31:0]  coord_type;

   typedef struct {
      logic       op;
      logic [1:0] vidx;
      coord_type  a [3];
      coord_type  b [3];
      bit         drain;
      int         gap;
   } request_type;

   typedef struct {
      logic        hit;
      logic [31:0] s;
   } crossing_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = 1'b0;
   logic [1:0]  req_vertex_index = 2'd0;
   coord_type   req_ax = '0, req_ay = '0, req_az = '0;
   coord_type   req_bx = '0, req_by = '0, req_bz = '0;
   logic        rsp_valid;
   logic        rsp_hit;
   logic [31:0] rsp_param_s;

   segment_triangle_intersect u_top (
      .clock, .reset, .start, .busy, .req_op, .req_vertex_index,
      .req_ax, .req_ay, .req_az, .req_bx, .req_by, .req_bz,
      .rsp_valid, .rsp_hit, .rsp_param_s
   );

   always #5 clock = ~clock;

   request_type  request_q [$];
   crossing_type crossing_q [$];
   coord_type    tri_vtx [9];
   bit        quiet = 0;
   bit        accepted = 0;
   int        gap_cnt = 0;
   int        errors = 0, n_tests = 0, n_hits = 0, n_loads = 0;

   // exact crossing test on the stored triangle
   function automatic crossing_type predict_crossing(coord_type pa [3], coord_type pb [3]);
      big_type v [3][3];
      big_type e1 [3], e2 [3], n [3], u [3], x0 [3], xp [3];
      big_type un, xn, num, den, vv, vw, ww, dd, dxw, dxv, aa, bb, ee;
      crossing_type r;
      r.hit = 1'b0;
      r.s   = '0;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            v[i][k] = tri_vtx[i*3+k];
      for (int k = 0; k < 3; k++) begin
         e1[k] = v[1][k] - v[0][k];
         e2[k] = v[2][k] - v[0][k];
         u[k]  = big_type'(pb[k]) - big_type'(pa[k]);
         x0[k] = big_type'(pa[k]) - v[0][k];
      end
      for (int k = 0; k < 3; k++)
         n[k] = e1[(k+1)%3] * e2[(k+2)%3] - e1[(k+2)%3] * e2[(k+1)%3];
      un = u[0]*n[0] + u[1]*n[1] + u[2]*n[2];
      if (un == 0) return r;
      xn  = x0[0]*n[0] + x0[1]*n[1] + x0[2]*n[2];
      num = -xn;
      den = un;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num <= 0 || num > den) return r;
      for (int k = 0; k < 3; k++)
         xp[k] = x0[k] * un - xn * u[k];
      vv = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
      vw = e1[0]*e2[0] + e1[1]*e2[1] + e1[2]*e2[2];
      ww = e2[0]*e2[0] + e2[1]*e2[1] + e2[2]*e2[2];
      dd = vw*vw - vv*ww;
      if (dd == 0) return r;
      dxw = xp[0]*e2[0] + xp[1]*e2[1] + xp[2]*e2[2];
      dxv = xp[0]*e1[0] + xp[1]*e1[1] + xp[2]*e1[2];
      aa = vw*dxw - ww*dxv;
      bb = vw*dxv - vv*dxw;
      ee = un * dd;
      if (ee < 0) begin
         aa = -aa;
         bb = -bb;
         ee = -ee;
      end
      if (aa < 0 || aa > ee) return r;
      if (bb < 0 || aa + bb > ee) return r;
      r.hit = 1'b1;
      r.s   = 32'((num <<< S_FRAC_BITS) / den);
      return r;
   endfunction

   function automatic int pick_gap();
      if (quiet || $urandom_range(0, 3) != 0) return 0;
      return $urandom_range(1, 13);
   endfunction

   task automatic push_load(int idx, coord_type x, coord_type y, coord_type z);
      request_type q;
      q.op = OP_LOAD;
      q.vidx = 2'(idx);
      q.a = '{x, y, z};
      q.b = '{coord_type'($urandom), coord_type'($urandom), coord_type'($urandom)};
      q.drain = 0;
      q.gap = pick_gap();
      request_q.insert(request_q.size(), q);
   endtask

   task automatic push_test(coord_type ax, coord_type ay, coord_type az,
                            coord_type bx, coord_type by, coord_type bz);
      request_type q;
      q.op = OP_TEST;
      q.vidx = 2'($urandom);
      q.a = '{ax, ay, az};
      q.b = '{bx, by, bz};
      q.drain = 0;
      q.gap = pick_gap();
      request_q.insert(request_q.size(), q);
   endtask

   task automatic push_drain();
      request_type q;
      q = '{default: 0};
      q.drain = 1;
      request_q.insert(request_q.size(), q);
   endtask

   function automatic coord_type rnd_coord(int sh);
      return $signed($urandom) >>> sh;
   endfunction

   // stimulus
   initial begin
      localparam coord_type ONE = 32'sh1_0000;
      coord_type c [3], d [3];
      int sh;
      // zero triangle at reset: parallel, no hit
      push_test(ONE, ONE, ONE, -ONE, 0, ONE);
      push_load(0, 0, 0, 0);
      push_load(1, ONE, 0, 0);
      push_load(2, 0, ONE, 0);
      push_load(3, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678); // ignored
      push_test(ONE/4, ONE/4, ONE, ONE/4, ONE/4, -ONE);      // s = 1/2
      push_test(ONE/4, ONE/4, ONE, ONE/4, ONE/4, 0);         // s = 1
      push_test(ONE/4, ONE/4, 0, ONE/4, ONE/4, -ONE);        // starts on plane
      push_test(ONE/2, ONE/2, ONE, ONE/2, ONE/2, -ONE);      // on hypotenuse
      push_test(0, 0, ONE, 0, 0, -3*ONE);                    // at a corner
      push_test(ONE, ONE, ONE, ONE, ONE, -ONE);              // outside
      push_test(0, 0, ONE, ONE, ONE, ONE);                   // parallel
      push_test(ONE/4, ONE/4, 3, ONE/4, ONE/4, 32'h8000_0000); // tiny s
      push_load(2, 2*ONE, 0, 0);                             // collinear
      push_test(ONE/4, 0, ONE, ONE/4, 0, -ONE);
      push_load(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_load(1, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
      push_load(2, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
      push_test(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      push_test(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                32'h0, 32'h8000_0000, 32'h7fff_ffff);
      push_drain();

      // random triangles with segments mostly aimed near their centroid
      for (int t = 0; t < 200; t++) begin
         if (t == 100) push_drain();
         if (t >= 175) quiet = 1;
         sh = (t % 10 == 0) ? 0 : $urandom_range(4, 18);
         if ($urandom_range(0, 9) == 0) begin
            push_load($urandom_range(0, 3), $urandom, $urandom, $urandom);
            push_test($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) c[k] = rnd_coord(sh);
            push_load(i, c[0], c[1], c[2]);
            for (int k = 0; k < 3; k++) tri_vtx[i*3+k] = c[k];
         end
         for (int j = 0; j < 5; j++) begin
            for (int k = 0; k < 3; k++) begin
               c[k] = coord_type'((longint'(tri_vtx[k]) + tri_vtx[3+k] + tri_vtx[6+k]) / 3
                      + (longint'(rnd_coord(sh)) >>> $urandom_range(0, 3)));
               d[k] = rnd_coord(sh);
            end
            if ($urandom_range(0, 3) == 0)
               push_test(rnd_coord(sh), rnd_coord(sh), rnd_coord(sh),
                         rnd_coord(sh), rnd_coord(sh), rnd_coord(sh));
            else
               push_test(c[0] + d[0], c[1] + d[1], c[2] + d[2],
                         c[0] - (d[0] >>> $urandom_range(0, 2)),
                         c[1] - (d[1] >>> $urandom_range(0, 2)),
                         c[2] - (d[2] >>> $urandom_range(0, 2)));
         end
      end
      foreach (tri_vtx[i]) tri_vtx[i] = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait (request_q.size() == 0 && crossing_q.size() == 0 && !start);
      repeat (50) @(posedge clock);
      $display("Ran %0d vertex loads and %0d segment tests, %0d of them hits.",
               n_loads, n_tests, n_hits);
      if (errors == 0)
         $display("segment_triangle_intersect: match");
      else
         $display("segment_triangle_intersect: mismatch");
      $finish;
   end

   // driver
   always @(negedge clock) begin
      request_type q;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accepted) begin
         if (gap_cnt > 0) begin
            gap_cnt <= gap_cnt - 1;
            start <= 1'b0;
         end else if (request_q.size() == 0) begin
            start <= 1'b0;
         end else if (request_q[0].drain) begin
            start <= 1'b0;
            if (crossing_q.size() == 0) void'(request_q.pop_front());
         end else begin
            q = request_q.pop_front();
            start <= 1'b1;
            req_op <= q.op;
            req_vertex_index <= q.vidx;
            req_ax <= q.a[0];
            req_ay <= q.a[1];
            req_az <= q.a[2];
            req_bx <= q.b[0];
            req_by <= q.b[1];
            req_bz <= q.b[2];
            gap_cnt <= q.gap;
         end
      end
   end

   // monitor and predictor update
   always @(posedge clock) begin
      crossing_type x;
      accepted <= !reset && start && !busy;
      if (!reset && rsp_valid) begin
         if (crossing_q.size() == 0) begin
            $error("response with no segment test pending");
            errors++;
         end else begin
            x = crossing_q.pop_front();
            if (rsp_hit !== x.hit) begin
               $error("hit: expected %0d, got %0d", x.hit, rsp_hit);
               errors++;
            end
            if (rsp_param_s !== x.s) begin
               $error("param_s: expected %h, got %h", x.s, rsp_param_s);
               errors++;
            end
         end
      end
      if (!reset && start && !busy) begin
         if (req_op == OP_LOAD) begin
            n_loads++;
            if (req_vertex_index != 2'd3) begin
               tri_vtx[req_vertex_index*3]   = req_ax;
               tri_vtx[req_vertex_index*3+1] = req_ay;
               tri_vtx[req_vertex_index*3+2] = req_az;
            end
         end else begin
            x = predict_crossing('{req_ax, req_ay, req_az}, '{req_bx, req_by, req_bz});
            n_tests++;
            n_hits += x.hit;
            crossing_q.insert(crossing_q.size(), x);
         end
      end
   end

   // watchdog on cycles without progress
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 40000) begin
         $display("segment_triangle_intersect: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
